/* design/apq_pkg.sv */
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants of the array priority queue
// Holds the item structs, status and kind codes, and the storage sizes.
// ----------------------------------------------------------------------------
package apq_pkg;

    // Storage size and derived widths.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the items.
    localparam int PRIO_W   = 32;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int ENTRY_W  = PRIO_W + TAG_W;

    // Item kinds.
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic signed [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]         tag;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [PRIO_W-1:0] out_priority;
        logic [TAG_W-1:0]         out_tag;
        logic [COUNT_W-1:0]       count;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic tail;
        logic move;
        logic post;
    } apq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic held_zero;
        logic scan_last;
        logic out_free;
    } apq_stat_t;

endpackage

/* design/array_priority_queue.sv */
// ----------------------------------------------------------------------------
// array_priority_queue: min-priority queue kept in an unsorted entry RAM
// Inserts append at the end; extracts scan for the smallest priority.
// ----------------------------------------------------------------------------
// Insert: accepted in idle, then posted to the output register. Extract of n
// held entries: scan, tail, move and post, with no new item taken before idle;
// the single RAM read port is walked once per entry, then once more for the
// last entry that fills the hole. Extract on an empty queue and insert on a
// full one go straight to posting, like an insert. A stalled result holds
// the controller in posting until the output register frees up.
// Reset clears the fill count and the control state at once; the entry RAM
// needs no clearing pass, since only positions below the fill count are read.
// ----------------------------------------------------------------------------
module array_priority_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  apq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output apq_pkg::rsp_item_t rsp
);

    import apq_pkg::*;

    // The controller sequences each item; the datapath owns all storage.
    apq_cmd_t  cmd;
    apq_stat_t st;

    // The controller takes an item only when idle. A finished result sits in
    // the datapath output register, so a new item may be taken while the
    // previous result still waits downstream.
    apq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .st        (st),
        .cmd       (cmd),
        .req_stall (req_stall)
    );

    // The datapath scans the RAM one entry per cycle, keeping the running
    // minimum, then moves the last entry into the slot that was removed.
    apq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

/* design/apq_ram.sv */
// ----------------------------------------------------------------------------
// apq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module apq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/apq_ctrl.sv */
// ----------------------------------------------------------------------------
// apq_ctrl: sequencing state machine of the array priority queue
// Accept, then scan, tail and move for a nonempty extract, then posting.
// ----------------------------------------------------------------------------
module apq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_kind,
    input  apq_pkg::apq_stat_t st,
    output apq_pkg::apq_cmd_t  cmd,
    output logic              req_stall
);

    import apq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_TAIL = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.accept     = req_valid && (state_reg == S_IDLE);
        cmd.scan_issue = (state_reg == S_SCAN);
        cmd.tail       = (state_reg == S_TAIL);
        cmd.move       = (state_reg == S_MOVE);
        cmd.post       = (state_reg == S_POST);
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    if (req_kind == KIND_EXTRACT && !st.held_zero)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_POST;
                    end
                end
            end
            S_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/apq_dp.sv */
// ----------------------------------------------------------------------------
// apq_dp: datapath of the array priority queue
// Entry RAM, fill count, running minimum and the output register.
// ----------------------------------------------------------------------------
module apq_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  apq_pkg::req_item_t req,
    input  apq_pkg::apq_cmd_t  cmd,
    output apq_pkg::apq_stat_t st,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output apq_pkg::rsp_item_t rsp
);

    import apq_pkg::*;

    logic [CNT_W-1:0]         held_reg, held_next;
    logic [ADDR_W-1:0]        scan_idx_reg, scan_idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [ADDR_W-1:0]        best_idx_reg, best_idx_next;
    logic signed [PRIO_W-1:0] best_prio_reg, best_prio_next;
    logic [TAG_W-1:0]         best_tag_reg, best_tag_next;
    logic [STATUS_W-1:0]      res_status_reg, res_status_next;
    logic signed [PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic [TAG_W-1:0]         res_tag_reg, res_tag_next;
    logic                     out_valid_reg, out_valid_next;
    rsp_item_t                out_data_reg, out_data_next;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]       ram_wdata;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic signed [PRIO_W-1:0] rd_prio;
    logic [TAG_W-1:0]         rd_tag;
    logic [CNT_W-1:0]         held_dec;
    logic                     held_full;

    apq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_prio   = ram_rdata[ENTRY_W-1 -: PRIO_W];
    assign rd_tag    = ram_rdata[TAG_W-1:0];
    assign held_dec  = held_reg - CNT_W'(1);
    assign held_full = (held_reg == CNT_W'(CAPACITY));

    assign st.held_zero = (held_reg == '0);
    assign st.scan_last = (CNT_W'(scan_idx_reg) == held_dec);
    assign st.out_free  = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    always_comb
    begin
        held_next       = held_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_tag_next   = best_tag_reg;
        res_status_next = res_status_reg;
        res_prio_next   = res_prio_reg;
        res_tag_next    = res_tag_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = held_reg[ADDR_W-1:0];
        ram_wdata       = {req.priority_req, req.tag};
        ram_raddr       = scan_idx_reg;

        if (cmd.accept)
        begin
            scan_idx_next = '0;
            res_prio_next = '0;
            res_tag_next  = '0;
            if (req.kind == KIND_INSERT)
            begin
                if (held_full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ram_we          = 1'b1;
                    held_next       = held_reg + CNT_W'(1);
                    res_status_next = ST_OK;
                end
            end
            else
            begin
                // Only reported when the queue is empty; a move overwrites it.
                res_status_next = ST_EMPTY;
            end
        end

        if (cmd.scan_issue)
        begin
            ram_raddr      = scan_idx_reg;
            scan_idx_next  = scan_idx_reg + ADDR_W'(1);
            cmp_valid_next = 1'b1;
            cmp_idx_next   = scan_idx_reg;
        end

        if (cmd.tail)
        begin
            // Fetch the last entry; it fills the hole left by the minimum.
            ram_raddr = held_dec[ADDR_W-1:0];
        end

        if (cmp_valid_reg)
        begin
            // Strict compare keeps the lowest position among equal priorities.
            if (cmp_idx_reg == '0 || rd_prio < best_prio_reg)
            begin
                best_idx_next  = cmp_idx_reg;
                best_prio_next = rd_prio;
                best_tag_next  = rd_tag;
            end
        end

        if (cmd.move)
        begin
            ram_we          = 1'b1;
            ram_waddr       = best_idx_reg;
            ram_wdata       = ram_rdata;
            held_next       = held_dec;
            res_status_next = ST_OK;
            res_prio_next   = best_prio_reg;
            res_tag_next    = best_tag_reg;
        end

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.post && st.out_free)
        begin
            out_valid_next             = 1'b1;
            out_data_next.status       = res_status_reg;
            out_data_next.out_priority = res_prio_reg;
            out_data_next.out_tag      = res_tag_reg;
            out_data_next.count        = COUNT_W'(held_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_tag_reg   <= best_tag_next;
        res_status_reg <= res_status_next;
        res_prio_reg   <= res_prio_next;
        res_tag_reg    <= res_tag_next;
        out_data_reg   <= out_data_next;
    end

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |-> (held_reg != '0))
        else $error("entry move with an empty queue");

    a_move_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move |=> (held_reg == $past(held_dec)))
        else $error("fill count not decremented after extract");

    a_post_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.post && st.out_free) |=> out_valid_reg)
        else $error("posted result not presented");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the array priority queue
// Drives insert and extract items through the request channel and checks
// every result item against a local model of the unsorted-array queue.
// The model keeps its own copy of the entries and the fill count.
// ----------------------------------------------------------------------------
module tb_top;
    import apq_pkg::*;

    // Size of the random part, the watchdog limit and the quiet time at the end.
    // The drain time covers the slowest item, an extract of a full queue, with
    // margin. The watchdog allows for long receiver stalls on top of that.
    localparam int RANDOM_ITEMS   = 1600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;

    // How the priorities of one burst of inserts are drawn.
    typedef enum int {PRIO_WIDE, PRIO_NARROW, PRIO_EDGE} prio_mode_e;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp;

    array_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Items waiting to be sent, and the results the model says must come back.
    req_item_t pending_reqs [$];
    rsp_item_t expected_rsp [$];

    // Model of the queue: entries in array order plus the fill count.
    logic signed [PRIO_W-1:0] model_prio [CAPACITY];
    logic [TAG_W-1:0]         model_tag  [CAPACITY];
    int                       model_held = 0;

    // Fill count as seen while the stimulus is planned. Every item changes
    // it the same way whatever the timing, so bursts can aim at full or empty.
    int gen_held    = 0;
    int total_items = 0;

    int issued       = 0;
    int results_seen = 0;
    int error_count  = 0;
    int idle_cycles  = 0;
    bit timed_out    = 1'b0;

    // Coverage tallies for the summary.
    int n_insert    = 0;
    int n_extract   = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int n_ties      = 0;
    int deepest     = 0;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // Idle rates by progress: in the first third the sender idles rarely and
    // the receiver often, in the second third the reverse, and in the last
    // third neither side idles at all.
    function automatic int idle_pct(int done, bit is_sender);
        if (done < total_items / 3)
            return is_sender ? 8 : 66;
        if (done < 2 * total_items / 3)
            return is_sender ? 66 : 8;
        return 0;
    endfunction

    // Applies one accepted item to the model and returns the result it causes.
    // An insert appends at the end unless the queue is full. An extract scans
    // for the smallest signed priority, keeping the first position on a tie,
    // and the last entry moves into the hole it leaves.
    function automatic rsp_item_t queue_apply(req_item_t item);
        rsp_item_t res;
        int        best;
        res = '0;
        if (item.kind == KIND_INSERT) begin
            n_insert++;
            if (model_held >= CAPACITY) begin
                res.status = ST_FULL;
                n_full++;
            end
            else begin
                model_prio[model_held] = item.priority_req;
                model_tag[model_held]  = item.tag;
                model_held++;
                res.status = ST_OK;
                if (model_held > deepest)
                    deepest = model_held;
            end
        end
        else begin
            n_extract++;
            if (model_held == 0) begin
                res.status = ST_EMPTY;
                n_empty++;
            end
            else begin
                best = 0;
                for (int i = 1; i < model_held; i++) begin
                    if (model_prio[i] < model_prio[best])
                        best = i;
                    else if (model_prio[i] == model_prio[best])
                        n_ties++;
                end
                res.status       = ST_OK;
                res.out_priority = model_prio[best];
                res.out_tag      = model_tag[best];
                model_held--;
                model_prio[best] = model_prio[model_held];
                model_tag[best]  = model_tag[model_held];
            end
        end
        res.count = COUNT_W'(model_held);
        return res;
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_priority(prio_mode_e mode);
        int v;
        case (mode)
            PRIO_NARROW:
            begin
                // A handful of values around zero, so equal priorities are common.
                v = $urandom_range(0, 8);
                return v - 4;
            end
            PRIO_EDGE:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'sh8000_0000;
                    1: return 32'sh8000_0001;
                    2: return 32'sh7FFF_FFFF;
                    3: return 32'sh7FFF_FFFE;
                    4: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_insert(logic signed [PRIO_W-1:0] p, logic [TAG_W-1:0] t);
        req_item_t item;
        item.kind         = KIND_INSERT;
        item.priority_req = p;
        item.tag          = t;
        pending_reqs.push_back(item);
        if (gen_held < CAPACITY)
            gen_held++;
    endfunction

    // The priority and tag of an extract are ignored, but get random bits anyway.
    function automatic void add_extract();
        req_item_t item;
        item.kind         = KIND_EXTRACT;
        item.priority_req = $urandom;
        item.tag          = TAG_W'($urandom_range(0, 16'hFFFF));
        pending_reqs.push_back(item);
        if (gen_held > 0)
            gen_held--;
    endfunction

    // Request driver. A new item goes out only when the channel is free, that
    // is, nothing was shown last cycle or the item shown was just taken. A
    // stalled item stays on the bus untouched. Valid and payload each get one
    // nonblocking assignment per edge.
    always @(posedge clk)
    begin
        req_item_t next_req;
        logic      next_valid;
        next_req   = req;
        next_valid = req_valid;
        if (rst_n) begin
            if (req_valid && !req_stall)
                next_valid = 1'b0;
            if (!next_valid && pending_reqs.size() != 0
                && $urandom_range(0, 99) >= idle_pct(issued, 1'b1)) begin
                next_req   = pending_reqs.pop_front();
                next_valid = 1'b1;
                issued++;
            end
        end
        req_valid <= next_valid;
        req       <= next_req;
    end

    // Result monitor. It also feeds the model from the request channel, so
    // checking a result and predicting a new one happen in a fixed order
    // within one process. A result is only shown after its own item has been
    // taken, so checking before predicting keeps the order right.
    always @(posedge clk)
    begin
        rsp_item_t want;
        logic      moved;
        rsp_stall <= ($urandom_range(0, 99) < idle_pct(results_seen, 1'b0));
        if (rst_n) begin
            moved = 1'b0;
            if (rsp_valid && !rsp_stall) begin
                moved = 1'b1;
                results_seen++;
                if (expected_rsp.size() == 0) begin
                    report_mismatch("result with nothing expected", 64'(rsp), '0);
                end
                else begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", 64'(rsp.status), 64'(want.status));
                    if (rsp.out_priority !== want.out_priority)
                        report_mismatch("out_priority", 64'(rsp.out_priority),
                                        64'(want.out_priority));
                    if (rsp.out_tag !== want.out_tag)
                        report_mismatch("out_tag", 64'(rsp.out_tag), 64'(want.out_tag));
                    if (rsp.count !== want.count)
                        report_mismatch("count", 64'(rsp.count), 64'(want.count));
                end
            end
            if (req_valid && !req_stall) begin
                moved = 1'b1;
                expected_rsp.push_back(queue_apply(req));
            end
            // The watchdog counts cycles in which neither channel moves an item.
            if (moved)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial
    begin
        int         directed;
        int         pick;
        prio_mode_e mode;

        // Directed part: extract on an empty queue, the priority extremes,
        // equal priorities at different positions, a full drain, and an
        // extract on the queue once it is empty again.
        add_extract();
        add_insert(32'sh7FFF_FFFF, 16'hFFFF);
        add_insert(32'sh8000_0000, 16'h0000);
        add_insert(32'sd0,         16'hAAAA);
        add_insert(-32'sd1,        16'h5555);
        add_insert(-32'sd1,        16'h1234);
        add_insert(32'sh8000_0000, 16'h00FF);
        repeat (6) add_extract();
        add_extract();
        directed = pending_reqs.size();

        // Random part in bursts. Fill bursts run the queue up to capacity and
        // then try a few more inserts, drain bursts empty it and extract past
        // the end, and mixed bursts wander in between.
        while (pending_reqs.size() < directed + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            mode = prio_mode_e'($urandom_range(0, 2));
            if (pick < 2) begin
                while (gen_held < CAPACITY)
                    add_insert(pick_priority(mode), TAG_W'($urandom_range(0, 16'hFFFF)));
                repeat ($urandom_range(1, 3))
                    add_insert(pick_priority(mode), TAG_W'($urandom_range(0, 16'hFFFF)));
            end
            else if (pick < 4) begin
                while (gen_held > 0)
                    add_extract();
                repeat ($urandom_range(1, 2))
                    add_extract();
            end
            else begin
                repeat ($urandom_range(8, 40)) begin
                    if ($urandom_range(0, 99) < (gen_held < 8 ? 70 : 50))
                        add_insert(pick_priority(mode),
                                   TAG_W'($urandom_range(0, 16'hFFFF)));
                    else
                        add_extract();
                end
            end
        end
        total_items = pending_reqs.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so the checks see settled state.
        while (!timed_out
               && (pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0))
            @(negedge clk);

        if (timed_out) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top: done, errors");
        end
        else begin
            // Quiet time for any stray result to show up.
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (expected_rsp.size() != 0)
                report_mismatch("results never delivered", 64'(expected_rsp.size()), '0);
            $display("summary: %0d items, %0d inserts (%0d refused as full), %0d extracts (%0d on empty)",
                     total_items, n_insert, n_full, n_extract, n_empty);
            $display("summary: deepest fill %0d, %0d equal-priority scans, %0d results, %0d mismatches",
                     deepest, n_ties, results_seen, error_count);
            if (error_count == 0)
                $display("tb_top: done, clean");
            else
                $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/apq_pkg.sv
design/apq_ram.sv
design/apq_ctrl.sv
design/apq_dp.sv
design/array_priority_queue.sv
tb/sv/tb_top.sv
